// File: design/ils_pkg.sv
// Package for the indexed list store: stream item layouts, operation and
// status codes, and the controller state type. No dependencies.
package ils_pkg;

    // Operation codes carried in the op field
    typedef enum logic [2:0] {
        OP_APPEND      = 3'd0,
        OP_REMOVE_LAST = 3'd1,
        OP_REMOVE_AT   = 3'd2,
        OP_READ        = 3'd3,
        OP_FIND_FIRST  = 3'd4,
        OP_FIND_LAST   = 3'd5
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_MISS  = 2'd1,
        STS_RANGE = 2'd2,
        STS_FULL  = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_SEARCH
    } state_t;

    // Input transfer layout, last declared field in the lowest bits
    typedef struct packed {
        logic [4:0]  pad;
        logic [31:0] value;
        logic [7:0]  position;
        logic [2:0]  op;
    } in_item_t;

    // Result transfer layout, last declared field in the lowest bits
    typedef struct packed {
        logic [4:0]  pad;
        logic [8:0]  entry_count;
        logic [31:0] read_value;
        logic [7:0]  found_position;
        status_t     status;
    } out_item_t;

    localparam int IN_TDATA_W  = $bits(in_item_t);
    localparam int OUT_TDATA_W = $bits(out_item_t);

endpackage

// File: design/ils_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No dependencies.
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/indexed_list_store.sv
// Indexed list store top level: controller, fill count and result register
// around one entry RAM. Depends on ils_pkg and ils_ram.
//
// Usage:
//   Operations arrive on the s_axis channel, one per transfer; each gives
//   exactly one result transfer on m_axis, in order. The list itself sits
//   in a single RAM with one read and one write port and registered read data.
//   How each operation runs, from acceptance to result in the output register:
//     append, remove last, failed checks, unused op codes: result registered on acceptance
//     read: the RAM read, then the result
//     remove at index p: entries above p are moved down one per cycle
//     find first / find last: one entry compared per cycle until a match or the end
//   The RAM read port sets this pace: each step reads one entry.
//   Operations run one at a time; s_axis_tready is high when the controller
//   is idle and the result register is empty or being emptied, so the next
//   operation can be taken in the same cycle as the previous result.
//   When m_axis_tready is low the result is held and no new operation is
//   taken. Reset empties the list (count zero) and the result register;
//   the RAM contents are not cleared, since only entries below the count
//   are ever read.
module indexed_list_store #(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // tdata: op[2:0], position[10:3], value[42:11], zero pad
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ils_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // tdata: status[1:0], found_position[9:2], read_value[41:10],
    //        entry_count[50:42], zero pad
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [ils_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = ((FW > 8) ? FW : 8) + 1;

    ils_pkg::in_item_t  in_item;
    ils_pkg::op_t       in_op;
    logic [VALUE_BITS-1:0] in_val;
    logic               in_fire;
    logic               pos_ok;

    ils_pkg::state_t    state_reg, state_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [VALUE_BITS-1:0] key_reg, key_next;
    logic               dir_last_reg, dir_last_next;
    logic               out_valid_reg, out_valid_next;
    ils_pkg::out_item_t out_data_reg, out_data_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;
    logic [63:0]           rdata_ext;

    ils_pkg::status_t   res_status;
    logic [7:0]         res_found;
    logic [31:0]        res_rdval;
    logic               load_out;

    // Entry memory
    ils_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Input decode
    assign in_item   = ils_pkg::in_item_t'(s_axis_tdata);
    assign in_op     = ils_pkg::op_t'(in_item.op);
    assign in_val    = VALUE_BITS'(in_item.value);
    assign pos_ok    = CW'(in_item.position) < CW'(fill_reg);
    assign rdata_ext = 64'(ram_rdata);

    assign s_axis_tready = (state_reg == ils_pkg::S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Next state, RAM access and result
    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        key_next      = key_reg;
        dir_last_next = dir_last_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = idx_reg;
        res_status    = ils_pkg::STS_OK;
        res_found     = '0;
        res_rdval     = '0;
        load_out      = 1'b0;

        unique case (state_reg)
            ils_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_op)
                        ils_pkg::OP_APPEND:
                        begin
                            load_out = 1'b1;
                            if (fill_reg == FW'(DEPTH))
                            begin
                                res_status = ils_pkg::STS_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(fill_reg);
                                ram_wdata = in_val;
                                fill_next = fill_reg + FW'(1);
                            end
                        end
                        ils_pkg::OP_REMOVE_LAST:
                        begin
                            load_out = 1'b1;
                            if (fill_reg == '0)
                            begin
                                res_status = ils_pkg::STS_RANGE;
                            end
                            else
                            begin
                                fill_next = fill_reg - FW'(1);
                            end
                        end
                        ils_pkg::OP_REMOVE_AT:
                        begin
                            if (!pos_ok)
                            begin
                                load_out   = 1'b1;
                                res_status = ils_pkg::STS_RANGE;
                            end
                            else if (CW'(in_item.position) + CW'(1) == CW'(fill_reg))
                            begin
                                // last entry: nothing to move
                                load_out  = 1'b1;
                                fill_next = fill_reg - FW'(1);
                            end
                            else
                            begin
                                ram_raddr  = AW'(CW'(in_item.position) + CW'(1));
                                idx_next   = AW'(in_item.position);
                                state_next = ils_pkg::S_SHIFT;
                            end
                        end
                        ils_pkg::OP_READ:
                        begin
                            if (!pos_ok)
                            begin
                                load_out   = 1'b1;
                                res_status = ils_pkg::STS_RANGE;
                            end
                            else
                            begin
                                ram_raddr  = AW'(in_item.position);
                                state_next = ils_pkg::S_READ;
                            end
                        end
                        ils_pkg::OP_FIND_FIRST,
                        ils_pkg::OP_FIND_LAST:
                        begin
                            if (fill_reg == '0)
                            begin
                                load_out   = 1'b1;
                                res_status = ils_pkg::STS_MISS;
                            end
                            else
                            begin
                                dir_last_next = (in_op == ils_pkg::OP_FIND_LAST);
                                key_next      = in_val;
                                idx_next      = (in_op == ils_pkg::OP_FIND_LAST) ?
                                                AW'(fill_reg - FW'(1)) : '0;
                                ram_raddr     = idx_next;
                                state_next    = ils_pkg::S_SEARCH;
                            end
                        end
                        default:
                        begin
                            // unused op codes: plain OK result
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ils_pkg::S_READ:
            begin
                load_out   = 1'b1;
                res_rdval  = rdata_ext[31:0];
                state_next = ils_pkg::S_IDLE;
            end
            ils_pkg::S_SHIFT:
            begin
                // RAM data is entry idx+1; move it down to idx
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                if (FW'(idx_reg) + FW'(2) == fill_reg)
                begin
                    load_out   = 1'b1;
                    fill_next  = fill_reg - FW'(1);
                    state_next = ils_pkg::S_IDLE;
                end
                else
                begin
                    idx_next  = idx_reg + AW'(1);
                    ram_raddr = AW'(FW'(idx_reg) + FW'(2));
                end
            end
            ils_pkg::S_SEARCH:
            begin
                // RAM data is entry idx
                if (ram_rdata == key_reg)
                begin
                    load_out   = 1'b1;
                    res_found  = 8'(idx_reg);
                    state_next = ils_pkg::S_IDLE;
                end
                else if (dir_last_reg ? (idx_reg == '0)
                                      : (FW'(idx_reg) + FW'(1) == fill_reg))
                begin
                    load_out   = 1'b1;
                    res_status = ils_pkg::STS_MISS;
                    state_next = ils_pkg::S_IDLE;
                end
                else
                begin
                    idx_next  = dir_last_reg ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));
                    ram_raddr = idx_next;
                end
            end
            default:
            begin
                state_next = ils_pkg::S_IDLE;
            end
        endcase

        // Result register
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        if (load_out)
        begin
            out_valid_next               = 1'b1;
            out_data_next.pad            = '0;
            out_data_next.status         = res_status;
            out_data_next.found_position = res_found;
            out_data_next.read_value     = res_rdval;
            out_data_next.entry_count    = 9'(fill_next);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ils_pkg::S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        key_reg      <= key_next;
        dir_last_reg <= dir_last_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(DEPTH))
        else $error("fill count above depth");

    a_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ils_pkg::S_IDLE) |-> !out_valid_reg)
        else $error("result pending while an operation is in progress");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ils_pkg::S_SHIFT) |-> (FW'(idx_reg) + FW'(1) < fill_reg))
        else $error("shift index beyond the list");

    a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ils_pkg::S_SEARCH) |-> (FW'(idx_reg) < fill_reg))
        else $error("search index beyond the list");

    a_fill_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ils_pkg::S_SEARCH || state_reg == ils_pkg::S_READ)
        |=> $stable(fill_reg))
        else $error("fill count changed by a read or search");

endmodule
